// ----- sv/hpc_pkg.sv -----
// ----------------------------------------------------------------------------
// hpc_pkg
// Shared widths, result codes and state type of the projective compare core.
// ----------------------------------------------------------------------------
package hpc_pkg;

  localparam int COEF_PORT_W = 32;
  localparam int COEF_BITS   = 32;
  localparam int SCALE_W     = COEF_BITS + 1;
  localparam int PROD_W      = SCALE_W + COEF_BITS;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [1:0] ORD_SMALLER = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_LARGER  = 2'd2;

  localparam logic REG_IDX_MODE = 1'b0;

  localparam logic MODE_WEAK   = 1'b0;
  localparam logic MODE_STRONG = 1'b1;

  typedef enum logic [2:0] {
    PH_SKIP = 3'b001,
    PH_CMP  = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  typedef struct packed {
    logic       early;
    logic [1:0] early_ord;
    logic       cmp;
    logic       last;
  } s2_ctl_t;

endpackage

// ----- sv/hyperplane_projective_compare_core.sv -----
// ----------------------------------------------------------------------------
// hyperplane_projective_compare_core
// Streams coefficient pairs of two hyperplanes and compares them projectively.
// ----------------------------------------------------------------------------
// Takes one coefficient pair per clock with no stalls of its own; the item
// carrying last_index produces a single order result once it has passed
// the input register, product register and output register. The rate
// is set by the two 33x32 signed multipliers in the first stage, which run
// every cycle against the held scale factors. The input stalls only while a
// finished result waits in the output register and another last item is
// ready to follow it. mode_r is sampled when the first pair that is
// not all zero reaches the first stage.
module hyperplane_projective_compare_core
  import hpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COEF_PORT_W-1:0] in_coef_first,
  input  logic [COEF_PORT_W-1:0] in_coef_second,
  input  logic                   in_last_index,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_order,

  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  // configuration
  logic mode_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_IDX_MODE);
  assign prdata = (paddr[CFG_ADDR_W-1] == REG_IDX_MODE) ?
                  {{(CFG_DATA_W-1){1'b0}}, mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_WEAK;
    end else if (cfg_wr) begin
      mode_r <= pwdata[0];
    end
  end

  // flow control
  logic advance;
  logic s1_valid_r;
  logic signed [COEF_BITS-1:0] a_r, b_r;
  logic s1_last_r;
  logic s2_valid_r;
  s2_ctl_t s2_ctl_r, s2_ctl_nxt;
  logic signed [PROD_W-1:0] prod_first_r, prod_second_r;
  logic out_valid_r;
  logic [1:0] out_order_r;

  assign advance  = !(s2_valid_r && s2_ctl_r.last && out_valid_r && !out_ready);
  assign in_ready = advance;

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_r       <= in_coef_first[COEF_BITS-1:0];
      b_r       <= in_coef_second[COEF_BITS-1:0];
      s1_last_r <= in_last_index;
    end
  end

  // stage 1: first-pair handling and products
  phase_t phase_r, phase_nxt;
  logic signed [SCALE_W-1:0] scale_first_r, scale_first_nxt;
  logic signed [SCALE_W-1:0] scale_second_r, scale_second_nxt;
  logic a_zero, b_zero, a_neg, b_neg;
  logic [1:0] rank_a, rank_b;
  logic signed [SCALE_W-1:0] a_ext, b_ext;
  logic signed [PROD_W-1:0] prod_first_nxt, prod_second_nxt;

  assign a_zero = (a_r == '0);
  assign b_zero = (b_r == '0);
  assign a_neg  = a_r[COEF_BITS-1];
  assign b_neg  = b_r[COEF_BITS-1];
  assign a_ext  = SCALE_W'(a_r);
  assign b_ext  = SCALE_W'(b_r);
  assign rank_a = a_zero ? 2'd1 : (a_neg ? 2'd0 : 2'd2);
  assign rank_b = b_zero ? 2'd1 : (b_neg ? 2'd0 : 2'd2);

  assign prod_first_nxt  = PROD_W'(scale_first_r) * PROD_W'(a_r);
  assign prod_second_nxt = PROD_W'(scale_second_r) * PROD_W'(b_r);

  always_comb begin
    phase_nxt             = phase_r;
    scale_first_nxt       = scale_first_r;
    scale_second_nxt      = scale_second_r;
    s2_ctl_nxt.early      = 1'b0;
    s2_ctl_nxt.early_ord  = ORD_EQUAL;
    s2_ctl_nxt.cmp        = (phase_r == PH_CMP);
    s2_ctl_nxt.last       = s1_last_r;
    if (phase_r == PH_SKIP && !(a_zero && b_zero)) begin
      if (mode_r == MODE_WEAK) begin
        if (a_zero) begin
          s2_ctl_nxt.early     = 1'b1;
          s2_ctl_nxt.early_ord = ORD_SMALLER;
          phase_nxt            = PH_DONE;
        end else if (b_zero) begin
          s2_ctl_nxt.early     = 1'b1;
          s2_ctl_nxt.early_ord = ORD_LARGER;
          phase_nxt            = PH_DONE;
        end else begin
          scale_first_nxt  = (a_neg ^ b_neg) ? -b_ext : b_ext;
          scale_second_nxt = (a_neg ^ b_neg) ? -a_ext : a_ext;
          phase_nxt        = PH_CMP;
        end
      end else begin
        if (rank_a != rank_b) begin
          s2_ctl_nxt.early     = 1'b1;
          s2_ctl_nxt.early_ord = (rank_a < rank_b) ? ORD_SMALLER : ORD_LARGER;
          phase_nxt            = PH_DONE;
        end else begin
          scale_first_nxt  = b_neg ? -b_ext : b_ext;
          scale_second_nxt = a_neg ? -a_ext : a_ext;
          phase_nxt        = PH_CMP;
        end
      end
    end
    if (s1_last_r) begin
      phase_nxt        = PH_SKIP;
      scale_first_nxt  = '0;
      scale_second_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_SKIP;
      scale_first_r  <= '0;
      scale_second_r <= '0;
    end else if (advance && s1_valid_r) begin
      phase_r        <= phase_nxt;
      scale_first_r  <= scale_first_nxt;
      scale_second_r <= scale_second_nxt;
    end
  end

  // stage 2: product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_ctl_r      <= s2_ctl_nxt;
      prod_first_r  <= prod_first_nxt;
      prod_second_r <= prod_second_nxt;
    end
  end

  // stage 2: cross compare and decision
  logic dec_r, dec_nxt;
  logic [1:0] dec_order_r, dec_order_nxt;
  logic [1:0] result_ord;

  always_comb begin
    dec_nxt       = dec_r;
    dec_order_nxt = dec_order_r;
    if (!dec_r) begin
      if (s2_ctl_r.early) begin
        dec_nxt       = 1'b1;
        dec_order_nxt = s2_ctl_r.early_ord;
      end else if (s2_ctl_r.cmp && (prod_first_r != prod_second_r)) begin
        dec_nxt       = 1'b1;
        dec_order_nxt = (prod_first_r < prod_second_r) ? ORD_SMALLER : ORD_LARGER;
      end
    end
    result_ord = dec_nxt ? dec_order_nxt : ORD_EQUAL;
    if (s2_ctl_r.last) begin
      dec_nxt       = 1'b0;
      dec_order_nxt = ORD_EQUAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r       <= 1'b0;
      dec_order_r <= ORD_EQUAL;
    end else if (advance && s2_valid_r) begin
      dec_r       <= dec_nxt;
      dec_order_r <= dec_order_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s2_valid_r && s2_ctl_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid_r && s2_ctl_r.last) begin
      out_order_r <= result_ord;
    end
  end

  assign out_valid = out_valid_r;
  assign out_order = out_order_r;

`ifndef SYNTHESIS
  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_valid_r && s2_ctl_r.last && advance))
    else $error("result without a last item");

  a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_order_r == ORD_SMALLER || out_order_r == ORD_EQUAL ||
                     out_order_r == ORD_LARGER))
    else $error("bad order code");

  a_ctl_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> !(s2_ctl_r.early && s2_ctl_r.cmp))
    else $error("early decision on a compare item");

  a_phase_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && advance) |=> (phase_r == PH_SKIP))
    else $error("phase not cleared after last item");

  a_dec_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_ctl_r.last && advance) |=> !dec_r)
    else $error("decision not cleared after last item");
`endif

endmodule

// ----- dv/hpc_order_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hpc_order_checker
// Predicts the order result of each coefficient stream and checks the core.
// ----------------------------------------------------------------------------
// Watches the input, result and register channels. Every accepted item is
// folded into a local model of the projective compare; an item with
// last_index queues the predicted order. Each accepted result is checked
// against the oldest queued order. Unexpected results and wrong orders
// count as mismatches. backlog tells the stimulus how many are still owed.
module hpc_order_checker
  import hpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [COEF_PORT_W-1:0] in_coef_first,
  input  logic [COEF_PORT_W-1:0] in_coef_second,
  input  logic                   in_last_index,

  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [1:0]             out_order,

  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  input  logic                   pready,

  output int                     mismatches,
  output int                     backlog
);

  localparam logic [CFG_ADDR_W-1:0] MODE_ADDR  = CFG_ADDR_W'(4 * REG_IDX_MODE);
  localparam int                    REPORT_MAX = 10;

  typedef enum logic [1:0] {
    SCAN_ZEROS,
    TRACK_RATIO,
    SETTLED
  } track_t;

  logic       mode_sel;
  track_t     track;
  longint     ratio_first;
  longint     ratio_second;
  logic [1:0] verdict;
  logic [1:0] pending_orders[$];
  logic [1:0] want_order;
  int         results_seen;

  function automatic longint coef_val(input logic [COEF_PORT_W-1:0] raw);
    logic signed [COEF_BITS-1:0] low;
    low = raw[COEF_BITS-1:0];
    return longint'(low);
  endfunction

  function automatic int sgn(input longint x);
    return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
  endfunction

  function automatic logic [1:0] order_of(input longint x, input longint y);
    if (x < y) return ORD_SMALLER;
    if (x > y) return ORD_LARGER;
    return ORD_EQUAL;
  endfunction

  task automatic fold_pair(input logic [COEF_PORT_W-1:0] a_raw,
                           input logic [COEF_PORT_W-1:0] b_raw,
                           input logic                   last);
    longint     x;
    longint     y;
    int         sx;
    int         sy;
    logic [1:0] c;
    x = coef_val(a_raw);
    y = coef_val(b_raw);
    case (track)
      SCAN_ZEROS: begin
        if (x != 0 || y != 0) begin
          sx = sgn(x);
          sy = sgn(y);
          if (mode_sel == MODE_WEAK) begin
            if (x == 0) begin
              verdict = ORD_SMALLER;
              track   = SETTLED;
            end else if (y == 0) begin
              verdict = ORD_LARGER;
              track   = SETTLED;
            end else begin
              ratio_first  = longint'(sx * sy) * y;
              ratio_second = longint'(sx * sy) * x;
              track        = TRACK_RATIO;
            end
          end else begin
            if (sx != sy) begin
              verdict = order_of(longint'(sx), longint'(sy));
              track   = SETTLED;
            end else begin
              ratio_first  = (y < 0) ? -y : y;
              ratio_second = (x < 0) ? -x : x;
              track        = TRACK_RATIO;
            end
          end
        end
      end
      TRACK_RATIO: begin
        c = order_of(ratio_first * x, ratio_second * y);
        if (c != ORD_EQUAL) begin
          verdict = c;
          track   = SETTLED;
        end
      end
      default: ;
    endcase
    if (last) begin
      pending_orders.push_back((track == SETTLED) ? verdict : ORD_EQUAL);
      track        = SCAN_ZEROS;
      ratio_first  = 0;
      ratio_second = 0;
      verdict      = ORD_EQUAL;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_sel     = MODE_WEAK;
      track        = SCAN_ZEROS;
      ratio_first  = 0;
      ratio_second = 0;
      verdict      = ORD_EQUAL;
      pending_orders.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == MODE_ADDR) begin
        mode_sel = pwdata[0];
      end
      if (in_valid && in_ready) begin
        fold_pair(in_coef_first, in_coef_second, in_last_index);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_orders.size() == 0) begin
          if (mismatches < REPORT_MAX) begin
            $display("%0t: result %0d unexpected, order=%0d", $realtime, results_seen,
                     out_order);
          end
          mismatches++;
        end else begin
          want_order = pending_orders.pop_front();
          if (out_order !== want_order) begin
            if (mismatches < REPORT_MAX) begin
              $display("%0t: result %0d order expected %0d got %0d", $realtime,
                       results_seen, want_order, out_order);
            end
            mismatches++;
          end
        end
      end
    end
    backlog = pending_orders.size();
  end

endmodule

// ----- dv/hyperplane_projective_compare_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hyperplane_projective_compare_core_tb
// Stream stimulus and verdict for the projective compare core.
// ----------------------------------------------------------------------------
// Drives hand-picked streams for the zero, sign, extreme and mode cases, then
// random streams, half of them proportional coefficient sets with an occasional
// perturbation so decisions land deep in a stream, plus noise. Both channels
// idle at random; one phase runs without gaps, one holds the result side off
// long enough to back up the input. Mode changes between random phases happen
// while the core is drained. hpc_order_checker does the prediction and comparison.
module hyperplane_projective_compare_core_tb;
  import hpc_pkg::*;

  localparam int                    RANDOM_ITEMS   = 1600;
  localparam int                    PHASES         = 8;
  localparam int                    HOLD_CYCLES    = 300;
  localparam int                    PRESSURE_ITEMS = 40;
  localparam int                    SETTLE_CYCLES  = 8;
  localparam int                    WATCHDOG_LIMIT = 4000;
  localparam logic [CFG_ADDR_W-1:0] MODE_ADDR      = CFG_ADDR_W'(4 * REG_IDX_MODE);
  localparam logic [COEF_PORT_W-1:0] C_MAX         = 32'h7fff_ffff;
  localparam logic [COEF_PORT_W-1:0] C_MIN         = 32'h8000_0000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [COEF_PORT_W-1:0] in_coef_first;
  logic [COEF_PORT_W-1:0] in_coef_second;
  logic                   in_last_index;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             out_order;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_ADDR_W-1:0]  paddr;
  logic [CFG_DATA_W-1:0]  pwdata;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  int   mismatches;
  int   backlog;
  bit   burst;
  bit   hold_req;
  int   items_sent;
  int   streams_sent;
  int   mode_writes;
  int   quiet_cycles;

  hyperplane_projective_compare_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_coef_first  (in_coef_first),
    .in_coef_second (in_coef_second),
    .in_last_index  (in_last_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_order      (out_order),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  hpc_order_checker u_order_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_coef_first  (in_coef_first),
    .in_coef_second (in_coef_second),
    .in_last_index  (in_last_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_order      (out_order),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .backlog        (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("hyperplane_projective_compare_core_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, a long hold on request, none in burst phases
  initial begin
    int stall_left;
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (!burst && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // entered and left at a falling edge; in_valid stays up for a back-to-back item
  task automatic push_pair(input logic [COEF_PORT_W-1:0] a,
                           input logic [COEF_PORT_W-1:0] b,
                           input logic                   last);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_coef_first  <= a;
    in_coef_second <= b;
    in_last_index  <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
    if (last) streams_sent++;
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    logic [CFG_DATA_W-1:0] r;
    r = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= {r[CFG_DATA_W-1:1], m};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mode_writes++;
  endtask

  function automatic longint signed_pick(input int unsigned hi);
    longint m;
    m = longint'($urandom_range(1, hi));
    return ($urandom_range(0, 1) == 1) ? -m : m;
  endfunction

  function automatic logic [COEF_PORT_W-1:0] corner_coef();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return COEF_PORT_W'(1);
      2:       return '1;
      3:       return C_MAX;
      4:       return C_MIN;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_stream();
    logic [COEF_PORT_W-1:0] fa[$];
    logic [COEF_PORT_W-1:0] fb[$];
    int                     n;
    int                     lead;
    int                     kind;
    int                     pos;
    longint                 p;
    longint                 q;
    longint                 v;
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
    lead = ($urandom_range(0, 2) == 0) ? $urandom_range(1, n) : 0;
    kind = $urandom_range(0, 9);
    p    = (kind < 3) ? signed_pick(1000) : signed_pick(32'h7fff_ffff);
    q    = (kind < 3) ? signed_pick(1000) : signed_pick(32'h7fff_ffff);
    for (int i = 0; i < n; i++) begin
      if (i < lead) begin
        fa.push_back('0);
        fb.push_back('0);
      end else if (kind < 3) begin
        v = longint'($urandom_range(0, 32'h0020_0000)) - 64'sh0010_0000;
        fa.push_back(COEF_PORT_W'(v * p));
        fb.push_back(COEF_PORT_W'(v * q));
      end else if (kind < 5) begin
        v = longint'($urandom_range(0, 2)) - 1;
        fa.push_back(COEF_PORT_W'(v * p));
        fb.push_back(COEF_PORT_W'(v * q));
      end else if (kind < 7) begin
        fa.push_back($urandom);
        fb.push_back($urandom);
      end else if (kind < 9) begin
        fa.push_back(COEF_PORT_W'(longint'($urandom_range(0, 6)) - 3));
        fb.push_back(COEF_PORT_W'(longint'($urandom_range(0, 6)) - 3));
      end else begin
        fa.push_back(corner_coef());
        fb.push_back(corner_coef());
      end
    end
    // break proportionality somewhere after the leading zeros
    if (kind < 5 && lead < n && $urandom_range(0, 1) == 1) begin
      pos = $urandom_range(lead, n - 1);
      fa[pos] = fa[pos] + COEF_PORT_W'($urandom_range(1, 3));
    end
    for (int i = 0; i < n; i++) begin
      push_pair(fa[i], fb[i], i == n - 1);
    end
  endtask

  initial begin
    int goal;
    in_valid       = 1'b0;
    in_coef_first  = '0;
    in_coef_second = '0;
    in_last_index  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    burst          = 1'b0;
    hold_req       = 1'b0;
    items_sent     = 0;
    streams_sent   = 0;
    mode_writes    = 0;
    quiet_cycles   = 0;
    rst_n          = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // weak mode from reset
    push_pair('0, '0, 1'b0);
    push_pair('0, '0, 1'b1);
    push_pair('0, '0, 1'b0);
    push_pair('0, 32'sd5, 1'b1);
    push_pair(32'sd7, '0, 1'b1);
    push_pair(C_MIN, C_MIN, 1'b0);
    push_pair(C_MAX, C_MAX, 1'b0);
    push_pair(C_MIN, C_MIN, 1'b1);
    push_pair(32'sd3, -32'sd6, 1'b0);
    push_pair(-32'sd1, 32'sd2, 1'b0);
    push_pair(32'sd5, -32'sd9, 1'b1);
    push_pair(32'sd1, 32'sd1, 1'b0);
    push_pair(32'sd2, 32'sd3, 1'b0);
    push_pair(32'sd5, 32'sd5, 1'b0);
    push_pair('0, '0, 1'b1);
    // mode switch after the first nonzero pair: weak scales stay
    push_pair(-32'sd2, 32'sd2, 1'b0);
    settle_block();
    write_mode(MODE_STRONG);
    push_pair(32'sd1, -32'sd1, 1'b1);
    push_pair(-32'sd4, 32'sd4, 1'b1);
    push_pair(32'sd4, '0, 1'b1);
    push_pair('0, -32'sd3, 1'b1);
    push_pair(-32'sd2, -32'sd4, 1'b0);
    push_pair(-32'sd1, -32'sd2, 1'b0);
    push_pair(C_MAX, C_MIN, 1'b1);
    // mode switch while still skipping zeros: the new mode applies
    push_pair('0, '0, 1'b0);
    settle_block();
    write_mode(MODE_WEAK);
    push_pair(-32'sd3, 32'sd3, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle_block();
      if (ph < 4) begin
        write_mode((ph % 2 == 1) ? MODE_STRONG : MODE_WEAK);
      end else begin
        write_mode(($urandom_range(0, 1) == 1) ? MODE_STRONG : MODE_WEAK);
      end
      burst = (ph == 5);
      if (ph == 2) begin
        // back up the core: results held off, single-item streams back to back
        burst = 1'b1;
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        repeat (PRESSURE_ITEMS) push_pair($urandom, $urandom, 1'b1);
        burst = 1'b0;
      end
      goal = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < goal) run_stream();
    end
    burst = 1'b0;
    settle_block();

    $display("sent %0d items in %0d streams with %0d mode writes", items_sent,
             streams_sent, mode_writes);
    $display("weak and strong modes, zero/sign/extreme cases, result hold backpressure");
    if (mismatches == 0 && backlog == 0) begin
      $display("hyperplane_projective_compare_core_tb: PASS");
    end else begin
      $display("hyperplane_projective_compare_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- hyperplane_projective_compare_core.f -----
sv/hpc_pkg.sv
sv/hyperplane_projective_compare_core.sv
dv/hpc_order_checker.sv
dv/hyperplane_projective_compare_core_tb.sv
